>>> sv/bu8v_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bu8v_pkg
// Shared types and constants of the bounded utf-8 text validator.
// ----------------------------------------------------------------------------
package bu8v_pkg;

  localparam int BYTE_W   = 8;
  localparam int REASON_W = 4;
  localparam int CP_W     = 21;

  localparam logic [BYTE_W-1:0] CAP_RESET  = 8'd32;
  localparam logic [BYTE_W-1:0] COUNT_MAX  = 8'hFF;
  localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;

  localparam logic [CP_W-1:0] CP_MAX      = 21'h10FFFF;
  localparam logic [CP_W-1:0] CP_SURR_LO  = 21'h00D800;
  localparam logic [CP_W-1:0] CP_SURR_HI  = 21'h00DFFF;
  localparam logic [CP_W-1:0] CP_C0_END   = 21'h000020;
  localparam logic [CP_W-1:0] CP_DEL      = 21'h00007F;
  localparam logic [CP_W-1:0] CP_C1_HI    = 21'h00009F;
  localparam logic [CP_W-1:0] CP_MIN_W2   = 21'h000080;
  localparam logic [CP_W-1:0] CP_MIN_W3   = 21'h000800;
  localparam logic [CP_W-1:0] CP_MIN_W4   = 21'h010000;

  localparam logic [2:0] SEQ_W1 = 3'd1;
  localparam logic [2:0] SEQ_W2 = 3'd2;
  localparam logic [2:0] SEQ_W3 = 3'd3;
  localparam logic [2:0] SEQ_W4 = 3'd4;

  typedef enum logic [REASON_W-1:0] {
    R_OK       = 4'd0,
    R_EMPTY    = 4'd1,
    R_LONG     = 4'd2,
    R_SPACE    = 4'd3,
    R_LEAD     = 4'd4,
    R_CONT     = 4'd5,
    R_OVERLONG = 4'd6,
    R_RANGE    = 4'd7,
    R_CONTROL  = 4'd8
  } reason_t;

  typedef struct packed {
    logic                text_valid;
    logic [REASON_W-1:0] fault_reason;
    logic [BYTE_W-1:0]   text_length;
  } result_t;

endpackage

>>> sv/bu8v_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bu8v_in_if / bu8v_out_if
// Valid/ready channels carrying text bytes in and verdicts out.
// ----------------------------------------------------------------------------
interface bu8v_in_if
  import bu8v_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

interface bu8v_out_if
  import bu8v_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                text_valid;
  logic [REASON_W-1:0] fault_reason;
  logic [BYTE_W-1:0]   text_length;

  modport source (output valid, output text_valid, output fault_reason,
                  output text_length, input ready);
  modport sink   (input valid, input text_valid, input fault_reason,
                  input text_length, output ready);
endinterface

>>> sv/bounded_utf8_text_validator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_utf8_text_validator
// Checks a zero-terminated byte string for length, edge spaces, strict
// utf-8 and control characters, and reports one verdict per string.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one text byte per transfer; a zero byte ends the text.
//   out_chan carries one verdict (text_valid, fault_reason, text_length) per
//   terminator, nothing for other bytes. cfg_wr_en/cfg_wr_data write the
//   text capacity, by the user only while the block is idle (not enforced).
// Timing:
//   one byte per cycle sustained while in_chan.ready is high; the decode
//   of a byte is short combinational logic between the per-text state
//   registers and the result register (or the skid entry when it is held).
// Reset:
//   rst_n (synchronous) clears the text state and the valid flags of both
//   result stages and sets the capacity to 32.
// Stall:
//   a result register plus one skid entry sit on the output; bytes keep
//   flowing while one verdict waits, and in_chan.ready drops only once a
//   second verdict is held in the skid entry.
// ----------------------------------------------------------------------------
module bounded_utf8_text_validator
  import bu8v_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [BYTE_W-1:0] cfg_wr_data,
  bu8v_in_if.sink           in_chan,
  bu8v_out_if.source        out_chan
);

  // text state
  logic [BYTE_W-1:0] cap_r;
  logic [BYTE_W-1:0] byte_count_r, byte_count_nxt;
  logic [1:0]        bytes_pending_r, bytes_pending_nxt;
  logic [2:0]        seq_width_r, seq_width_nxt;
  logic [CP_W-1:0]   code_accum_r, code_accum_nxt;
  reason_t           first_fault_r, first_fault_nxt;
  logic              first_space_r, first_space_nxt;
  logic              last_space_r, last_space_nxt;

  // output stages
  logic    out_valid_r, skid_valid_r;
  result_t out_data_r, skid_data_r;
  result_t res;
  reason_t reason;

  logic              in_fire, out_fire, is_term, is_space;
  logic [BYTE_W-1:0] b;
  logic [CP_W-1:0]   cp_full;
  logic [1:0]        pend_dec;
  reason_t           cp_res;

  function automatic reason_t check_point(logic [CP_W-1:0] cp, logic [2:0] w);
    if ((w == SEQ_W2 && cp < CP_MIN_W2) || (w == SEQ_W3 && cp < CP_MIN_W3) ||
        (w == SEQ_W4 && cp < CP_MIN_W4))
      return R_OVERLONG;
    if (cp > CP_MAX || (cp >= CP_SURR_LO && cp <= CP_SURR_HI))
      return R_RANGE;
    if (cp < CP_C0_END || (cp >= CP_DEL && cp <= CP_C1_HI))
      return R_CONTROL;
    return R_OK;
  endfunction

  assign b        = in_chan.text_byte;
  assign in_fire  = in_chan.valid && in_chan.ready;
  assign out_fire = out_valid_r && out_chan.ready;
  assign is_term  = (b == CHAR_NUL);
  assign is_space = (b == CHAR_SPACE);
  assign in_chan.ready = !skid_valid_r;

  assign cp_full  = {code_accum_r[CP_W-7:0], b[5:0]};
  assign pend_dec = bytes_pending_r - 2'd1;

  // verdict at the terminator
  always_comb begin
    if (byte_count_r >= cap_r) begin
      reason = R_LONG;
    end else if (byte_count_r == '0) begin
      reason = R_EMPTY;
    end else if (first_space_r || last_space_r) begin
      reason = R_SPACE;
    end else if (first_fault_r != R_OK) begin
      reason = first_fault_r;
    end else if (bytes_pending_r != 2'd0) begin
      reason = R_CONT;
    end else begin
      reason = R_OK;
    end
    res.text_valid   = (reason == R_OK);
    res.fault_reason = reason;
    res.text_length  = byte_count_r;
  end

  // per-byte state update and utf-8 decode
  always_comb begin
    byte_count_nxt    = byte_count_r;
    bytes_pending_nxt = bytes_pending_r;
    seq_width_nxt     = seq_width_r;
    code_accum_nxt    = code_accum_r;
    first_fault_nxt   = first_fault_r;
    first_space_nxt   = first_space_r;
    last_space_nxt    = last_space_r;
    cp_res            = R_OK;

    if (is_term) begin
      byte_count_nxt    = '0;
      bytes_pending_nxt = '0;
      seq_width_nxt     = '0;
      code_accum_nxt    = '0;
      first_fault_nxt   = R_OK;
      first_space_nxt   = 1'b0;
      last_space_nxt    = 1'b0;
    end else begin
      if (byte_count_r == '0) begin
        first_space_nxt = is_space;
      end
      last_space_nxt = is_space;
      if (byte_count_r != COUNT_MAX) begin
        byte_count_nxt = byte_count_r + 8'd1;
      end

      // decoding stops after the first fault
      if (first_fault_r == R_OK) begin
        if (bytes_pending_r != 2'd0) begin
          if (b[7:6] != 2'b10) begin
            first_fault_nxt   = R_CONT;
            bytes_pending_nxt = '0;
            seq_width_nxt     = '0;
            code_accum_nxt    = '0;
          end else if (pend_dec == 2'd0) begin
            cp_res            = check_point(cp_full, seq_width_r);
            first_fault_nxt   = cp_res;
            bytes_pending_nxt = '0;
            seq_width_nxt     = '0;
            code_accum_nxt    = '0;
          end else begin
            bytes_pending_nxt = pend_dec;
            code_accum_nxt    = cp_full;
          end
        end else begin
          case (b) inside
            [8'h01:8'h7F]: begin
              cp_res          = check_point({13'd0, b}, SEQ_W1);
              first_fault_nxt = cp_res;
            end
            [8'hC2:8'hDF]: begin
              code_accum_nxt    = {16'd0, b[4:0]};
              seq_width_nxt     = SEQ_W2;
              bytes_pending_nxt = 2'd1;
            end
            [8'hE0:8'hEF]: begin
              code_accum_nxt    = {17'd0, b[3:0]};
              seq_width_nxt     = SEQ_W3;
              bytes_pending_nxt = 2'd2;
            end
            [8'hF0:8'hF4]: begin
              code_accum_nxt    = {18'd0, b[2:0]};
              seq_width_nxt     = SEQ_W4;
              bytes_pending_nxt = 2'd3;
            end
            default: begin
              first_fault_nxt = R_LEAD;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r           <= CAP_RESET;
      byte_count_r    <= '0;
      bytes_pending_r <= '0;
      seq_width_r     <= '0;
      code_accum_r    <= '0;
      first_fault_r   <= R_OK;
      first_space_r   <= 1'b0;
      last_space_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (in_fire) begin
        byte_count_r    <= byte_count_nxt;
        bytes_pending_r <= bytes_pending_nxt;
        seq_width_r     <= seq_width_nxt;
        code_accum_r    <= code_accum_nxt;
        first_fault_r   <= first_fault_nxt;
        first_space_r   <= first_space_nxt;
        last_space_r    <= last_space_nxt;
      end
    end
  end

  // result register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_fire) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_fire && is_term;
      end
    end else if (in_fire && is_term) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_fire) begin
      out_data_r <= skid_valid_r ? skid_data_r : res;
    end else if (in_fire && is_term) begin
      skid_data_r <= res;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.text_valid   = out_data_r.text_valid;
  assign out_chan.fault_reason = out_data_r.fault_reason;
  assign out_chan.text_length  = out_data_r.text_length;

  // checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held while result register empty");

  a_term_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && is_term) |=> (byte_count_r == '0 && bytes_pending_r == 2'd0))
    else $error("text state not cleared after terminator");

  a_pending_width: assert property (@(posedge clk) disable iff (!rst_n)
    (bytes_pending_r != 2'd0) |-> (seq_width_r > {1'b0, bytes_pending_r}))
    else $error("pending count exceeds sequence width");

  a_verdict_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.text_valid == (out_data_r.fault_reason == R_OK)))
    else $error("verdict disagrees with reason code");

endmodule

>>> sim/bounded_utf8_text_validator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_utf8_text_validator_tb
// Sends zero-terminated byte strings through the validator and checks
// every verdict against its table entry or a cycle-free model of the
// length, edge-space and strict utf-8 rules. A short table of hand-picked
// strings comes first. Then several capacity settings follow, the extremes
// among them, each with a run of mostly well-formed random text with flaws
// mixed in. Both channels idle at random, and the output is held off once
// so that the block fills up and stalls its input.
// ----------------------------------------------------------------------------
module bounded_utf8_text_validator_tb;
  import bu8v_pkg::*;

  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 3;
  localparam int HOLD_CYCLES   = 60;
  localparam int PHASE_BYTES   = 68;
  localparam int LONG_TEXT     = 300;
  localparam int NUM_PHASES    = 9;
  localparam int NUM_PROBES    = 9;
  localparam int BURST_TEXTS   = 4;

  // one directed string, terminator included, first byte in the top lane
  typedef struct packed {
    logic [2:0]  n;
    logic [39:0] seq;
    logic        typed;
    result_t     want;
  } probe_t;

  localparam probe_t PROBES [NUM_PROBES] = '{
    '{3'd1, 40'h00_00_00_00_00, 1'b1, '{1'b0, R_EMPTY,    8'd0}},
    '{3'd2, 40'h20_00_00_00_00, 1'b1, '{1'b0, R_SPACE,    8'd1}},
    '{3'd3, 40'h41_FF_00_00_00, 1'b1, '{1'b0, R_LEAD,     8'd2}},
    '{3'd4, 40'hE0_80_80_00_00, 1'b1, '{1'b0, R_OVERLONG, 8'd3}},
    '{3'd4, 40'hED_A0_80_00_00, 1'b1, '{1'b0, R_RANGE,    8'd3}},
    '{3'd3, 40'hC2_41_00_00_00, 1'b1, '{1'b0, R_CONT,     8'd2}},
    '{3'd3, 40'hE2_82_00_00_00, 1'b1, '{1'b0, R_CONT,     8'd2}},
    '{3'd3, 40'hC2_80_00_00_00, 1'b1, '{1'b0, R_CONTROL,  8'd2}},
    '{3'd5, 40'hF0_9F_98_80_00, 1'b0, '{1'b0, R_OK,       8'd0}}
  };

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [BYTE_W-1:0] cfg_wr_data;

  bu8v_in_if  in_if ();
  bu8v_out_if out_if ();

  bounded_utf8_text_validator dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_chan     (in_if),
    .out_chan    (out_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model state of the validator
  logic [BYTE_W-1:0]   text_cap;
  logic [BYTE_W-1:0]   seen_count;
  logic [1:0]          cont_left;
  logic [2:0]          seq_len;
  logic [CP_W-1:0]     cp_acc;
  reason_t             first_err;
  logic                opened_space;
  logic                closed_space;

  result_t             expected_verdicts [$];
  logic [BYTE_W-1:0]   text_buf [$];
  int                  errors = 0;
  int                  idle_cycles = 0;
  bit                  hold_req = 1'b0;
  bit                  steady_send = 1'b0;

  function automatic void clear_text_state();
    seen_count   = '0;
    cont_left    = '0;
    seq_len      = '0;
    cp_acc       = '0;
    first_err    = R_OK;
    opened_space = 1'b0;
    closed_space = 1'b0;
  endfunction

  function automatic void note_flaw(reason_t r);
    if (first_err == R_OK) begin
      first_err = r;
    end
    cont_left = '0;
    seq_len   = '0;
    cp_acc    = '0;
  endfunction

  function automatic reason_t classify_point(logic [CP_W-1:0] cp, logic [2:0] w);
    if ((w == SEQ_W2 && cp < CP_MIN_W2) || (w == SEQ_W3 && cp < CP_MIN_W3) ||
        (w == SEQ_W4 && cp < CP_MIN_W4)) begin
      return R_OVERLONG;
    end
    if (cp > CP_MAX || (cp >= CP_SURR_LO && cp <= CP_SURR_HI)) begin
      return R_RANGE;
    end
    if (cp < CP_C0_END || (cp >= CP_DEL && cp <= CP_C1_HI)) begin
      return R_CONTROL;
    end
    return R_OK;
  endfunction

  function automatic void advance_decode(logic [BYTE_W-1:0] b);
    reason_t r;
    // once a flaw is seen only counting and space tracking go on
    if (first_err != R_OK) begin
      return;
    end
    if (cont_left != 2'd0) begin
      if (b[7:6] != 2'b10) begin
        note_flaw(R_CONT);
        return;
      end
      cp_acc    = {cp_acc[CP_W-7:0], b[5:0]};
      cont_left = cont_left - 2'd1;
      if (cont_left == 2'd0) begin
        r       = classify_point(cp_acc, seq_len);
        seq_len = '0;
        cp_acc  = '0;
        if (r != R_OK) begin
          note_flaw(r);
        end
      end
      return;
    end
    if (b < 8'h80) begin
      r = classify_point({13'd0, b}, SEQ_W1);
      if (r != R_OK) begin
        note_flaw(r);
      end
    end else if (b >= 8'hC2 && b <= 8'hDF) begin
      cp_acc = {16'd0, b[4:0]};
      seq_len = SEQ_W2;
      cont_left = 2'd1;
    end else if (b >= 8'hE0 && b <= 8'hEF) begin
      cp_acc = {17'd0, b[3:0]};
      seq_len = SEQ_W3;
      cont_left = 2'd2;
    end else if (b >= 8'hF0 && b <= 8'hF4) begin
      cp_acc = {18'd0, b[2:0]};
      seq_len = SEQ_W4;
      cont_left = 2'd3;
    end else begin
      note_flaw(R_LEAD);
    end
  endfunction

  // returns 1 when the byte is a terminator and v holds its verdict
  function automatic bit predict_verdict(input logic [BYTE_W-1:0] b, output result_t v);
    reason_t r;
    v = '0;
    if (b != CHAR_NUL) begin
      if (seen_count == 8'd0) begin
        opened_space = (b == CHAR_SPACE);
      end
      closed_space = (b == CHAR_SPACE);
      if (seen_count != COUNT_MAX) begin
        seen_count = seen_count + 8'd1;
      end
      advance_decode(b);
      return 1'b0;
    end
    if (seen_count >= text_cap) begin
      r = R_LONG;
    end else if (seen_count == 8'd0) begin
      r = R_EMPTY;
    end else if (opened_space || closed_space) begin
      r = R_SPACE;
    end else if (first_err != R_OK) begin
      r = first_err;
    end else if (cont_left != 2'd0) begin
      r = R_CONT;
    end else begin
      r = R_OK;
    end
    v.text_valid   = (r == R_OK);
    v.fault_reason = r;
    v.text_length  = seen_count;
    clear_text_state();
    return 1'b1;
  endfunction

  // stimulus text building

  function automatic void put_point(logic [CP_W-1:0] cp, int w);
    case (w)
      1: text_buf.push_back(cp[7:0]);
      2: begin
        text_buf.push_back({3'b110, cp[10:6]});
        text_buf.push_back({2'b10, cp[5:0]});
      end
      3: begin
        text_buf.push_back({4'b1110, cp[15:12]});
        text_buf.push_back({2'b10, cp[11:6]});
        text_buf.push_back({2'b10, cp[5:0]});
      end
      default: begin
        text_buf.push_back({5'b11110, cp[20:18]});
        text_buf.push_back({2'b10, cp[17:12]});
        text_buf.push_back({2'b10, cp[11:6]});
        text_buf.push_back({2'b10, cp[5:0]});
      end
    endcase
  endfunction

  // a legal code point for a multi-byte form, never a control or surrogate
  function automatic logic [CP_W-1:0] legal_point(int w);
    logic [CP_W-1:0] cp;
    case (w)
      2: cp = CP_W'($urandom_range(32'hA0, 32'h7FF));
      3: begin
        cp = CP_W'($urandom_range(32'h800, 32'hFFFF));
        if (cp >= CP_SURR_LO && cp <= CP_SURR_HI) begin
          cp = cp ^ CP_W'(32'h2000);
        end
      end
      default: cp = CP_W'($urandom_range(32'h10000, 32'h10FFFF));
    endcase
    return cp;
  endfunction

  function automatic void put_clean_char();
    case ($urandom_range(0, 9))
      0: text_buf.push_back(CHAR_SPACE);
      1, 2, 3, 4: text_buf.push_back(8'($urandom_range(32'h21, 32'h7E)));
      5, 6: put_point(legal_point(2), 2);
      7, 8: put_point(legal_point(3), 3);
      default: put_point(legal_point(4), 4);
    endcase
  endfunction

  function automatic void put_flaw();
    int w;
    logic [CP_W-1:0] cp;
    logic [BYTE_W-1:0] c;
    w = $urandom_range(2, 4);
    case ($urandom_range(0, 8))
      0: text_buf.push_back(8'($urandom_range(1, 255)));
      1: begin
        // c0 range or del
        c = 8'($urandom_range(1, 32));
        text_buf.push_back((c == 8'd32) ? 8'h7F : c);
      end
      2: put_point(CP_W'($urandom_range(32'h80, 32'h9F)), 2);
      3: begin
        // too few bits for the width; a two-byte one lands on a bad lead
        cp = CP_W'($urandom_range(0, (w == 2) ? 32'h7F : (w == 3) ? 32'h7FF : 32'hFFFF));
        put_point(cp, w);
      end
      4: put_point(CP_W'($urandom_range(32'hD800, 32'hDFFF)), 3);
      5: put_point(CP_W'($urandom_range(32'h110000, 32'h1FFFFF)), 4);
      6: begin
        if ($urandom_range(0, 1) == 0) begin
          text_buf.push_back(8'($urandom_range(32'h80, 32'hC1)));
        end else begin
          text_buf.push_back(8'($urandom_range(32'hF5, 32'hFF)));
        end
      end
      7: begin
        // sequence cut short
        put_point(legal_point(w), w);
        repeat ($urandom_range(1, w - 1)) void'(text_buf.pop_back());
      end
      default: begin
        text_buf.push_back(8'($urandom_range(32'hC2, 32'hF4)));
        if ($urandom_range(0, 1) == 0) begin
          text_buf.push_back(8'($urandom_range(1, 32'h7F)));
        end else begin
          text_buf.push_back(8'($urandom_range(32'hC0, 32'hFF)));
        end
      end
    endcase
  endfunction

  function automatic void compose_text(int max_chars);
    int kind;
    int nchar;
    int flaw_at;
    text_buf.delete();
    kind = $urandom_range(0, 99);
    if (kind < 4) begin
      return;
    end
    // raw noise
    if (kind < 10) begin
      repeat ($urandom_range(1, 10)) text_buf.push_back(8'($urandom_range(1, 255)));
      return;
    end
    if ($urandom_range(0, 9) == 0) begin
      text_buf.push_back(CHAR_SPACE);
    end
    nchar = $urandom_range(1, max_chars);
    flaw_at = -1;
    if (kind < 40) begin
      flaw_at = ($urandom_range(0, 2) == 0) ? nchar - 1 : $urandom_range(0, nchar - 1);
    end
    for (int i = 0; i < nchar; i++) begin
      if (i == flaw_at) begin
        put_flaw();
      end else begin
        put_clean_char();
      end
    end
    if ($urandom_range(0, 9) == 0) begin
      text_buf.push_back(CHAR_SPACE);
    end
  endfunction

  // channel drivers

  task automatic send_byte(input logic [BYTE_W-1:0] b, input bit use_typed,
                           input result_t typed);
    int gap;
    result_t got;
    gap = steady_send ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.text_byte <= b;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    if (predict_verdict(b, got)) begin
      expected_verdicts.push_back(use_typed ? typed : got);
    end
  endtask

  task automatic send_text();
    steady_send = ($urandom_range(0, 3) == 0);
    foreach (text_buf[i]) begin
      send_byte(text_buf[i], 1'b0, '0);
    end
    send_byte(CHAR_NUL, 1'b0, '0);
  endtask

  task automatic drain_and_settle();
    in_if.valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [BYTE_W-1:0] cap);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cap;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    text_cap = cap;
  endtask

  function automatic void flag_field(string field, logic [BYTE_W-1:0] want,
                                     logic [BYTE_W-1:0] got);
    errors++;
    $display("%0t %s mismatch: expected %0d, got %0d", $time, field, want, got);
  endfunction

  task automatic take_verdict();
    result_t want;
    if (expected_verdicts.size() == 0) begin
      errors++;
      $display("%0t unexpected verdict: expected none, got valid=%0b reason=%0d length=%0d",
               $time, out_if.text_valid, out_if.fault_reason, out_if.text_length);
    end else begin
      want = expected_verdicts.pop_front();
      if (out_if.text_valid !== want.text_valid) begin
        flag_field("text_valid", {7'd0, want.text_valid}, {7'd0, out_if.text_valid});
      end
      if (out_if.fault_reason !== want.fault_reason) begin
        flag_field("fault_reason", {4'd0, want.fault_reason}, {4'd0, out_if.fault_reason});
      end
      if (out_if.text_length !== want.text_length) begin
        flag_field("text_length", want.text_length, out_if.text_length);
      end
    end
  endtask

  initial begin : verdict_sink
    int stall;
    int fast_left;
    fast_left = 0;
    out_if.ready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if (hold_req) begin
        // long hold-off so the skid entry fills and the input stalls
        hold_req = 1'b0;
        stall = HOLD_CYCLES;
      end else if (fast_left > 0) begin
        fast_left--;
        stall = 0;
      end else begin
        stall = $urandom_range(0, 8);
        if ($urandom_range(0, 4) == 0) begin
          fast_left = $urandom_range(4, 12);
        end
      end
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (out_if.valid !== 1'b1);
      take_verdict();
    end
  end

  // no transfer on either side for too long means the block is stuck
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int phase_bytes;
    logic [BYTE_W-1:0] cap;
    cfg_wr_en       <= 1'b0;
    cfg_wr_data     <= '0;
    in_if.valid     <= 1'b0;
    in_if.text_byte <= '0;
    rst_n           <= 1'b0;
    text_cap = CAP_RESET;
    clear_text_state();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed strings at the reset capacity
    for (int r = 0; r < NUM_PROBES; r++) begin
      for (int i = 0; i < PROBES[r].n; i++) begin
        send_byte(PROBES[r].seq[39 - 8*i -: 8], PROBES[r].typed, PROBES[r].want);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0, 8: cap = COUNT_MAX;
        1: cap = 8'd1;
        2: cap = 8'd0;
        3: cap = 8'd6;
        default: cap = 8'($urandom_range(2, 40));
      endcase
      drain_and_settle();
      write_capacity(cap);
      if (ph == 4) begin
        hold_req = 1'b1;
        // back-to-back empty texts pile up behind the held output
        steady_send = 1'b1;
        repeat (BURST_TEXTS) send_byte(CHAR_NUL, 1'b0, '0);
      end
      if (ph == 0) begin
        // a text well past the capacity; the byte count saturates at 255
        text_buf.delete();
        repeat (LONG_TEXT) text_buf.push_back(8'h61);
        send_text();
      end
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) begin
        compose_text(10);
        send_text();
        phase_bytes += text_buf.size() + 1;
      end
    end

    drain_and_settle();
    repeat (8) @(posedge clk);
    if (errors == 0 && expected_verdicts.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
sv/bu8v_pkg.sv
sv/bu8v_if.sv
sv/bounded_utf8_text_validator.sv
sim/bounded_utf8_text_validator_tb.sv
